// ----- rtl/chained_printable_shift_cipher_core_macros.svh -----
// assertion macros for the chained printable shift cipher core
`ifndef CHAINED_PRINTABLE_SHIFT_CIPHER_CORE_MACROS_SVH
`define CHAINED_PRINTABLE_SHIFT_CIPHER_CORE_MACROS_SVH

// condition must hold in the same cycle as the trigger
`define CPSC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// condition must hold in the cycle after the trigger
`define CPSC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/cpsc_pkg.sv -----
// shared types and constants of the chained printable shift cipher core
package cpsc_pkg;

    // field widths
    localparam int CHAR_W     = 7;
    localparam int SUM_W      = 14;
    localparam int CFG_LEN_W  = 6;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 6;

    // divider operand widths: sums plus a character fit in the dividend
    localparam int DIVIDEND_W = 15;
    localparam int DIVISOR_W  = 7;

    // printable range
    localparam logic [CHAR_W-1:0] CHAR_LOW  = 7'd32;
    localparam logic [CHAR_W-1:0] CHAR_HIGH = 7'd126;
    localparam logic [CHAR_W-1:0] CHAR_SPAN = 7'd95;

    // item function codes
    localparam logic FUNC_LOAD = 1'b0;
    localparam logic FUNC_TEXT = 1'b1;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_KEY_LENGTH   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_DECRYPT_MODE = 1'b1;

    // divider request and response
    typedef struct packed {
        logic                  start;
        logic [DIVIDEND_W-1:0] dividend;
        logic [DIVISOR_W-1:0]  divisor;
    } div_req_t;

    typedef struct packed {
        logic                  busy;
        logic                  done;
        logic [DIVIDEND_W-1:0] quotient;
        logic [DIVISOR_W-1:0]  remainder;
    } div_rsp_t;

endpackage

// ----- rtl/cpsc_ram.sv -----
// generic single write port ram with registered read
module cpsc_ram #(
    parameter int WIDTH = 7,
    parameter int DEPTH = 32
) (
    input  logic                                       aclk,
    input  logic                                       we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                           wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                           rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write and registered read
    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/cpsc_div.sv -----
// iterative restoring divider, one quotient bit per cycle
module cpsc_div (
    input  logic               aclk,
    input  logic               aresetn,
    input  cpsc_pkg::div_req_t req,
    output cpsc_pkg::div_rsp_t rsp
);

    import cpsc_pkg::*;

    localparam int DCNT_W = $clog2(DIVIDEND_W);

    logic                  busy_reg;
    logic                  done_reg;
    logic [DCNT_W-1:0]     cnt_reg;
    logic [DIVIDEND_W-1:0] quo_reg;
    logic [DIVISOR_W-1:0]  rem_reg;
    logic [DIVISOR_W-1:0]  dsr_reg;

    logic [DIVISOR_W:0]    trial;
    logic [DIVISOR_W:0]    diff;
    logic                  fits;

    // one trial subtraction
    always_comb begin
        trial = {rem_reg, quo_reg[DIVIDEND_W-1]};
        diff  = trial - {1'b0, dsr_reg};
        fits  = (trial >= {1'b0, dsr_reg});
    end

    // step sequencing
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (busy_reg) begin
                quo_reg <= {quo_reg[DIVIDEND_W-2:0], fits};
                rem_reg <= fits ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
                cnt_reg <= cnt_reg + DCNT_W'(1);
                if (cnt_reg == DCNT_W'(DIVIDEND_W - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end else if (req.start) begin
                quo_reg  <= req.dividend;
                rem_reg  <= '0;
                dsr_reg  <= req.divisor;
                cnt_reg  <= '0;
                busy_reg <= 1'b1;
            end
        end
    end

    assign rsp.busy      = busy_reg;
    assign rsp.done      = done_reg;
    assign rsp.quotient  = quo_reg;
    assign rsp.remainder = rem_reg;

endmodule

// ----- rtl/chained_printable_shift_cipher_core.sv -----
// top level of the chained printable shift cipher core
//
// Usage: a keyword is loaded as items with s_func low, one character each;
// the item with s_last set ends the keyword. Text items (s_func high) then
// each give one result on m_out_char/m_out_last; s_last ends a message and
// restarts the key chain from the keyword. Load items give no result.
// Registers: index 0 key_length (block length), index 1 decrypt_mode,
// written on the cfg channel, which is always ready; write only while idle.
// A load item that ends the keyword also copies the keyword into the current
// key ram. A text item runs on the shared one-bit-per-cycle divider: two
// shift divisions always, plus up to two more for the modulo-95 wrap. The
// first item of a block adds the sum sweep; the last item of a block or
// message adds the key copy through the ram.
// Reset clears the control state and the sums; key rams are not cleared.
// A stalled result is held in the output register; the next item is still
// accepted and worked on, and its result waits until the register is free.
`include "chained_printable_shift_cipher_core_macros.svh"

module chained_printable_shift_cipher_core #(
    parameter int KEY_MAX = 32
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [cpsc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [cpsc_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic                            s_func,
    input  logic [cpsc_pkg::CHAR_W-1:0]     s_text_char,
    input  logic                            s_last,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [cpsc_pkg::CHAR_W-1:0]     m_out_char,
    output logic                            m_out_last
);

    import cpsc_pkg::*;

    localparam int KIDX_W = (KEY_MAX > 1) ? $clog2(KEY_MAX) : 1;
    localparam int CNT_W  = (CFG_LEN_W > $clog2(KEY_MAX + 1)) ? CFG_LEN_W
                                                              : $clog2(KEY_MAX + 1);
    localparam logic [CNT_W-1:0] KEY_MAX_C = CNT_W'(KEY_MAX);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LOAD,
        ST_SUM,
        ST_FETCH,
        ST_DIV_CUR,
        ST_SHIFT_OUT,
        ST_WRAP_OUT,
        ST_DIV_BASE,
        ST_SHIFT_KEY,
        ST_WRAP_KEY,
        ST_WRITE,
        ST_COPY
    } state_t;

    state_t                state_reg;

    // configuration
    logic [CFG_LEN_W-1:0]  key_length_reg;
    logic                  decrypt_mode_reg;

    // chain state
    logic [CNT_W-1:0]      load_cnt_reg;
    logic [KIDX_W-1:0]     pos_reg;
    logic [SUM_W-1:0]      cur_sum_reg;
    logic [SUM_W-1:0]      base_sum_reg;

    // item being worked on
    logic                  last_reg;
    logic [CHAR_W-1:0]     char_reg;
    logic [KIDX_W-1:0]     p_reg;
    logic [CHAR_W-1:0]     kb_reg;
    logic [CHAR_W-1:0]     kc_reg;
    logic [DIVIDEND_W-1:0] sh_reg;
    logic [DIVIDEND_W-1:0] wrap_dvd_reg;
    logic [CHAR_W-1:0]     res_reg;
    logic [CHAR_W-1:0]     nk_reg;
    logic                  div_run_reg;

    // sweeps over the key rams
    logic [CNT_W-1:0]      sweep_reg;
    logic                  rd_vld_reg;
    logic                  rd_odd_reg;
    logic [KIDX_W-1:0]     wr_addr_reg;
    logic                  copy_next_reg;

    // output register
    logic                  m_valid_reg;
    logic [CHAR_W-1:0]     m_char_reg;
    logic                  m_last_reg;

    logic [CNT_W-1:0]      eff_len;
    logic [KIDX_W-1:0]     p_sel;
    logic [CNT_W-1:0]      p_inc;
    logic                  out_free;
    logic [KIDX_W-1:0]     sweep_idx;

    logic                  base_we;
    logic [KIDX_W-1:0]     base_raddr;
    logic [CHAR_W-1:0]     base_rdata;
    logic                  cur_we;
    logic [KIDX_W-1:0]     cur_raddr;
    logic [CHAR_W-1:0]     cur_wdata;
    logic [CHAR_W-1:0]     cur_rdata;
    logic                  next_we;
    logic [CHAR_W-1:0]     next_rdata;

    logic [CHAR_W-1:0]     sh_c;
    logic                  sh_back;
    logic [DIVIDEND_W:0]   fwd_sum;
    logic [DIVIDEND_W:0]   back_lim;
    logic [DIVIDEND_W:0]   back_dvd;
    logic                  wrap_needed;
    logic [DIVIDEND_W-1:0] wrap_dvd;
    logic [CHAR_W-1:0]     direct_char;
    logic [DIVIDEND_W-1:0] div_shift;

    div_req_t              div_req;
    div_rsp_t              div_rsp;

    // effective block length and position of an incoming text item
    always_comb begin
        if (key_length_reg == '0) begin
            eff_len = CNT_W'(1);
        end else if (CNT_W'(key_length_reg) > KEY_MAX_C) begin
            eff_len = KEY_MAX_C;
        end else begin
            eff_len = CNT_W'(key_length_reg);
        end
        p_sel     = (CNT_W'(pos_reg) >= eff_len) ? '0 : pos_reg;
        p_inc     = CNT_W'(p_reg) + CNT_W'(1);
        out_free  = !m_valid_reg || m_ready;
        sweep_idx = sweep_reg[KIDX_W-1:0];
    end

    // key ram ports
    always_comb begin
        base_we    = (state_reg == ST_LOAD) && (load_cnt_reg < KEY_MAX_C);
        base_raddr = ((state_reg == ST_SUM) || (state_reg == ST_COPY)) ? sweep_idx : p_reg;
        cur_we     = (state_reg == ST_COPY) && rd_vld_reg;
        cur_wdata  = copy_next_reg ? next_rdata : base_rdata;
        cur_raddr  = (state_reg == ST_SUM) ? sweep_idx : p_reg;
        next_we    = (state_reg == ST_WRITE) && out_free;
    end

    cpsc_ram #(.WIDTH(CHAR_W), .DEPTH(KEY_MAX)) u_base_ram (
        .aclk  (aclk),
        .we    (base_we),
        .waddr (load_cnt_reg[KIDX_W-1:0]),
        .wdata (char_reg),
        .raddr (base_raddr),
        .rdata (base_rdata)
    );

    cpsc_ram #(.WIDTH(CHAR_W), .DEPTH(KEY_MAX)) u_cur_ram (
        .aclk  (aclk),
        .we    (cur_we),
        .waddr (wr_addr_reg),
        .wdata (cur_wdata),
        .raddr (cur_raddr),
        .rdata (cur_rdata)
    );

    cpsc_ram #(.WIDTH(CHAR_W), .DEPTH(KEY_MAX)) u_next_ram (
        .aclk  (aclk),
        .we    (next_we),
        .waddr (p_reg),
        .wdata (nk_reg),
        .raddr (sweep_idx),
        .rdata (next_rdata)
    );

    // shift step: direct result or dividend for the modulo-95 wrap
    always_comb begin
        sh_back = (state_reg == ST_SHIFT_OUT) && decrypt_mode_reg;
        sh_c    = ((state_reg == ST_SHIFT_KEY) && !decrypt_mode_reg) ? res_reg : char_reg;
        fwd_sum  = (DIVIDEND_W + 1)'(sh_c) + (DIVIDEND_W + 1)'(sh_reg);
        back_lim = (DIVIDEND_W + 1)'(sh_reg) + (DIVIDEND_W + 1)'(CHAR_LOW);
        back_dvd = (DIVIDEND_W + 1)'(sh_reg) + (DIVIDEND_W + 1)'(CHAR_HIGH)
                 - (DIVIDEND_W + 1)'(sh_c);
        if (sh_back) begin
            wrap_needed = back_lim > (DIVIDEND_W + 1)'(sh_c);
            wrap_dvd    = back_dvd[DIVIDEND_W-1:0];
            direct_char = sh_c - sh_reg[CHAR_W-1:0];
        end else begin
            wrap_needed = fwd_sum > (DIVIDEND_W + 1)'(CHAR_HIGH);
            wrap_dvd    = DIVIDEND_W'(fwd_sum - (DIVIDEND_W + 1)'(CHAR_LOW));
            direct_char = fwd_sum[CHAR_W-1:0];
        end
    end

    // divider request
    always_comb begin
        div_req.start    = 1'b0;
        div_req.dividend = wrap_dvd_reg;
        div_req.divisor  = CHAR_SPAN;
        case (state_reg) inside
            ST_DIV_CUR: begin
                div_req.start    = !div_run_reg;
                div_req.dividend = DIVIDEND_W'(cur_sum_reg);
                div_req.divisor  = cur_rdata;
            end
            ST_DIV_BASE: begin
                div_req.start    = !div_run_reg;
                div_req.dividend = DIVIDEND_W'(base_sum_reg);
                div_req.divisor  = kb_reg;
            end
            ST_WRAP_OUT, ST_WRAP_KEY: begin
                div_req.start    = !div_run_reg;
            end
            default: begin
                div_req.start    = 1'b0;
            end
        endcase
        div_shift = div_rsp.quotient + DIVIDEND_W'(div_rsp.remainder);
    end

    cpsc_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    // sequencer, chain state and output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= ST_IDLE;
            key_length_reg   <= CFG_LEN_W'(1);
            decrypt_mode_reg <= 1'b0;
            load_cnt_reg     <= '0;
            pos_reg          <= '0;
            cur_sum_reg      <= '0;
            base_sum_reg     <= '0;
            div_run_reg      <= 1'b0;
            rd_vld_reg       <= 1'b0;
            m_valid_reg      <= 1'b0;
        end else begin
            // configuration writes
            if (cfg_valid) begin
                unique case (cfg_index)
                    REG_KEY_LENGTH:   key_length_reg   <= cfg_data;
                    REG_DECRYPT_MODE: decrypt_mode_reg <= cfg_data[0];
                    default:          key_length_reg   <= key_length_reg;
                endcase
            end

            // output valid: set from the write state, cleared by a transfer
            if ((state_reg == ST_WRITE) && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE: begin
                    if (s_valid) begin
                        char_reg <= s_text_char;
                        last_reg <= s_last;
                        p_reg    <= p_sel;
                        if (s_func == FUNC_LOAD) begin
                            state_reg <= ST_LOAD;
                        end else if (p_sel == '0) begin
                            sweep_reg    <= '0;
                            rd_vld_reg   <= 1'b0;
                            cur_sum_reg  <= '0;
                            base_sum_reg <= '0;
                            state_reg    <= ST_SUM;
                        end else begin
                            state_reg <= ST_FETCH;
                        end
                    end
                end

                ST_LOAD: begin
                    if (last_reg) begin
                        load_cnt_reg  <= '0;
                        pos_reg       <= '0;
                        copy_next_reg <= 1'b0;
                        sweep_reg     <= '0;
                        rd_vld_reg    <= 1'b0;
                        state_reg     <= ST_COPY;
                    end else begin
                        if (load_cnt_reg < KEY_MAX_C) begin
                            load_cnt_reg <= load_cnt_reg + CNT_W'(1);
                        end
                        state_reg <= ST_IDLE;
                    end
                end

                // weighted sums of current and base key, one entry a cycle
                ST_SUM: begin
                    if (sweep_reg < eff_len) begin
                        sweep_reg  <= sweep_reg + CNT_W'(1);
                        rd_vld_reg <= 1'b1;
                        rd_odd_reg <= sweep_reg[0];
                    end else begin
                        rd_vld_reg <= 1'b0;
                    end
                    if (rd_vld_reg) begin
                        cur_sum_reg  <= cur_sum_reg + (rd_odd_reg ? SUM_W'({cur_rdata, 1'b0})
                                                                  : SUM_W'(cur_rdata));
                        base_sum_reg <= base_sum_reg + (rd_odd_reg ? SUM_W'({base_rdata, 1'b0})
                                                                   : SUM_W'(base_rdata));
                    end
                    if ((sweep_reg >= eff_len) && !rd_vld_reg) begin
                        state_reg <= ST_FETCH;
                    end
                end

                ST_FETCH: begin
                    state_reg <= ST_DIV_CUR;
                end

                // shift from the current key
                ST_DIV_CUR: begin
                    if (!div_run_reg) begin
                        kc_reg      <= cur_rdata;
                        kb_reg      <= base_rdata;
                        div_run_reg <= 1'b1;
                    end else if (div_rsp.done) begin
                        div_run_reg <= 1'b0;
                        sh_reg      <= (kc_reg == '0) ? '0 : div_shift;
                        state_reg   <= ST_SHIFT_OUT;
                    end
                end

                ST_SHIFT_OUT: begin
                    wrap_dvd_reg <= wrap_dvd;
                    res_reg      <= direct_char;
                    state_reg    <= wrap_needed ? ST_WRAP_OUT : ST_DIV_BASE;
                end

                ST_WRAP_OUT: begin
                    if (!div_run_reg) begin
                        div_run_reg <= 1'b1;
                    end else if (div_rsp.done) begin
                        div_run_reg <= 1'b0;
                        res_reg     <= decrypt_mode_reg ? (CHAR_HIGH - div_rsp.remainder)
                                                        : (CHAR_LOW + div_rsp.remainder);
                        state_reg   <= ST_DIV_BASE;
                    end
                end

                // shift from the base key for the next key entry
                ST_DIV_BASE: begin
                    if (!div_run_reg) begin
                        div_run_reg <= 1'b1;
                    end else if (div_rsp.done) begin
                        div_run_reg <= 1'b0;
                        sh_reg      <= (kb_reg == '0) ? '0 : div_shift;
                        state_reg   <= ST_SHIFT_KEY;
                    end
                end

                ST_SHIFT_KEY: begin
                    wrap_dvd_reg <= wrap_dvd;
                    nk_reg       <= direct_char;
                    state_reg    <= wrap_needed ? ST_WRAP_KEY : ST_WRITE;
                end

                ST_WRAP_KEY: begin
                    if (!div_run_reg) begin
                        div_run_reg <= 1'b1;
                    end else if (div_rsp.done) begin
                        div_run_reg <= 1'b0;
                        nk_reg      <= CHAR_LOW + div_rsp.remainder;
                        state_reg   <= ST_WRITE;
                    end
                end

                // store next key entry, hand out result, advance the block
                ST_WRITE: begin
                    if (out_free) begin
                        m_char_reg  <= res_reg;
                        m_last_reg  <= last_reg;
                        sweep_reg   <= '0;
                        rd_vld_reg  <= 1'b0;
                        if (last_reg) begin
                            pos_reg       <= '0;
                            copy_next_reg <= 1'b0;
                            state_reg     <= ST_COPY;
                        end else if (p_inc >= eff_len) begin
                            pos_reg       <= '0;
                            copy_next_reg <= 1'b1;
                            state_reg     <= ST_COPY;
                        end else begin
                            pos_reg   <= p_inc[KIDX_W-1:0];
                            state_reg <= ST_IDLE;
                        end
                    end
                end

                // copy base or next key into the current key ram
                ST_COPY: begin
                    if (sweep_reg < KEY_MAX_C) begin
                        sweep_reg   <= sweep_reg + CNT_W'(1);
                        rd_vld_reg  <= 1'b1;
                        wr_addr_reg <= sweep_idx;
                    end else begin
                        rd_vld_reg <= 1'b0;
                    end
                    if ((sweep_reg >= KEY_MAX_C) && !rd_vld_reg) begin
                        state_reg <= ST_IDLE;
                    end
                end

                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign cfg_ready  = 1'b1;
    assign s_ready    = (state_reg == ST_IDLE);
    assign m_valid    = m_valid_reg;
    assign m_out_char = m_char_reg;
    assign m_out_last = m_last_reg;

    // checks
    `CPSC_ASSERT_NOW(a_idle_div_quiet, state_reg == ST_IDLE, !div_rsp.busy, "divider busy while idle")
    `CPSC_ASSERT_NOW(a_out_from_write, $rose(m_valid_reg), $past(state_reg) == ST_WRITE, "result raised outside write state")
    `CPSC_ASSERT_NEXT(a_write_outputs, (state_reg == ST_WRITE) && out_free, m_valid_reg, "write state did not present result")
    `CPSC_ASSERT_NOW(a_load_bound, 1'b1, load_cnt_reg <= KEY_MAX_C, "keyword load count past capacity")

endmodule
